[hdl/precision_switch_and_lambda_policy_unit_macros.svh]
// Assertion macros for the precision switch and lambda policy unit.
`ifndef PRECISION_SWITCH_AND_LAMBDA_POLICY_UNIT_MACROS_SVH
`define PRECISION_SWITCH_AND_LAMBDA_POLICY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PSLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PSLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pslp_pkg.sv]
// Package: types, constants and helpers for the precision switch and lambda policy.
`default_nettype none
package pslp_pkg;

  localparam int unsigned COND_W  = 24;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned LAM_W   = 16;
  localparam int unsigned HOLD_W  = 16;

  typedef enum logic [1:0] {
    MODE_FIXED   = 2'd0,
    MODE_FLOAT   = 2'd1,
    MODE_HYB_VAR = 2'd2,
    MODE_HYB_FIX = 2'd3
  } pslp_mode_t;

  typedef enum logic [1:0] {
    CFG_MODE        = 2'd0,
    CFG_BASE_LAMBDA = 2'd1,
    CFG_COND_LIMIT  = 2'd2,
    CFG_HOLD_WINDOW = 2'd3
  } pslp_cfg_idx_t;

  localparam logic [LAM_W-1:0]  LAM_MIN       = 16'd57016;
  localparam logic [LAM_W-1:0]  LAM_MAX       = 16'd65208;
  localparam logic [LAM_W-1:0]  LAM_BASE_MIN  = 16'd58982;
  localparam logic [LAM_W-1:0]  LAM_MID_STEP  = 16'd1638;
  localparam logic [LAM_W-1:0]  LAM_FAST_STEP = 16'd3604;
  localparam logic [LAM_W-1:0]  LAM_RESET     = 16'd62587;
  localparam logic [COND_W-1:0] COND_DEFAULT  = 24'd256000;
  localparam logic [COND_W-1:0] COND_FLOOR    = 24'd56320;

  localparam logic [1:0] TRIG_MAX      = 2'd2;
  localparam logic [2:0] CALM_MAX      = 3'd5;
  localparam logic [5:0] COOLDOWN_LOAD = 6'd32;
  localparam logic [5:0] FAST_LOAD     = 6'd40;
  localparam logic [3:0] RUN_MAX       = 4'd15;
  localparam logic [3:0] RUN_HIT       = 4'd6;

  typedef struct packed {
    logic              float_active;
    logic [HOLD_W-1:0] hold_count;
    logic [1:0]        trigger_run;
    logic [2:0]        calm_run;
    logic [5:0]        reentry_cooldown;
    logic [5:0]        fast_hold;
    logic [3:0]        steady_run;
    logic [3:0]        extreme_run;
    logic [LAM_W-1:0]  lambda_store;
  } pslp_state_t;

  typedef struct packed {
    pslp_mode_t        mode;
    logic [LAM_W-1:0]  base_lambda;
    logic [COND_W-1:0] cond_limit;
    logic [HOLD_W-1:0] hold_window;
  } pslp_cfg_t;

  typedef struct packed {
    logic               restart;
    logic [COND_W-1:0]  cond_est;
    logic [DELTA_W-1:0] delta_norm;
    logic [SCALE_W-1:0] input_scale;
    logic               switch_hint;
    logic               core_overflow;
    logic               migration_ok;
    logic [LAM_W-1:0]   bridge_lambda;
  } pslp_frame_t;

  typedef struct packed {
    logic             use_float;
    logic [LAM_W-1:0] lambda_used;
    logic             want_float;
    logic             migrate_request;
    logic             migrate_direction;
    logic             migrate_done;
    logic             active_float;
    logic [LAM_W-1:0] next_lambda;
  } pslp_result_t;

  function automatic logic [LAM_W-1:0] clamp_lam(input logic [LAM_W-1:0] x,
                                                 input logic [LAM_W-1:0] lo,
                                                 input logic [LAM_W-1:0] hi);
    logic [LAM_W-1:0] y;
    y = x;
    if (y < lo) y = lo;
    if (y > hi) y = hi;
    return y;
  endfunction

endpackage
`default_nettype wire

[hdl/pslp_core.sv]
// Per-frame policy decision: next state and result from current state and frame.
`default_nettype none
module pslp_core (
  input  pslp_pkg::pslp_state_t  st,
  input  pslp_pkg::pslp_cfg_t    cfg,
  input  pslp_pkg::pslp_frame_t  frm,
  output pslp_pkg::pslp_state_t  st_nxt,
  output pslp_pkg::pslp_result_t res
);
  import pslp_pkg::*;

  logic [COND_W-1:0] thr;
  logic [LAM_W-1:0]  lam_req, lb, lm, lf, bridge_c;

  // scaled terms for the rational compares
  logic [30:0] cond_x100, thr_x92, thr_x72;
  logic [25:0] cond_x4, thr_x3, thr_x4;
  logic [26:0] cond_x5;
  logic [24:0] cond_x2;
  logic [28:0] thr_x24;
  logic [22:0] dn_x100;
  logic [20:0] dn_x20;
  logic [18:0] dn_x5;
  logic [22:0] sc_x100;
  logic [19:0] sc_x10;

  logic enter_hit, c_34, d_34, c_half, sc_gt1, calm_c, trig_hit;
  logic dn_020, dn_005, burst;

  pslp_state_t      s0, sn;
  logic [5:0]       cd1;
  logic             target, req, dir, done;
  logic [LAM_W-1:0] lam_eff, lam_next;

  assign thr     = (cfg.cond_limit != '0) ? cfg.cond_limit : COND_DEFAULT;
  assign lam_req = clamp_lam(cfg.base_lambda, LAM_MIN, LAM_MAX);
  assign lb      = clamp_lam(cfg.base_lambda, LAM_BASE_MIN, LAM_MAX);
  assign lm      = (lb < LAM_BASE_MIN + LAM_MID_STEP) ? LAM_BASE_MIN : lb - LAM_MID_STEP;
  assign lf      = (lb < LAM_MIN + LAM_FAST_STEP) ? LAM_MIN : lb - LAM_FAST_STEP;
  assign bridge_c = clamp_lam(frm.bridge_lambda, LAM_MIN, LAM_MAX);

  assign cond_x100 = 31'(frm.cond_est) * 31'd100;
  assign thr_x92   = 31'(thr) * 31'd92;
  assign thr_x72   = 31'(thr) * 31'd72;
  assign cond_x4   = {frm.cond_est, 2'b00};
  assign thr_x3    = 26'(thr) * 26'd3;
  assign thr_x4    = {thr, 2'b00};
  assign cond_x5   = 27'(frm.cond_est) * 27'd5;
  assign cond_x2   = {frm.cond_est, 1'b0};
  assign thr_x24   = 29'(thr) * 29'd24;
  assign dn_x100   = 23'(frm.delta_norm) * 23'd100;
  assign dn_x20    = 21'(frm.delta_norm) * 21'd20;
  assign dn_x5     = 19'(frm.delta_norm) * 19'd5;
  assign sc_x100   = 23'(frm.input_scale) * 23'd100;
  assign sc_x10    = 20'(frm.input_scale) * 20'd10;

  assign enter_hit = (cond_x100 > thr_x92) && (frm.cond_est > COND_FLOOR);
  assign c_34      = cond_x4 > thr_x3;
  assign d_34      = dn_x100 > 23'd139264;
  assign c_half    = cond_x2 > 25'(thr);
  assign sc_gt1    = frm.input_scale > 16'd256;
  assign calm_c    = (cond_x100 < thr_x72) && (dn_x100 < 23'd65536) &&
                     (sc_x100 < 23'd37120) && !frm.core_overflow;
  assign dn_020    = dn_x5 > 19'd4096;
  assign dn_005    = dn_x20 < 21'd4096;

  always_comb begin
    s0 = st;
    if (frm.restart) begin
      s0              = '0;
      s0.float_active = (cfg.mode == MODE_FLOAT);
      s0.lambda_store = lam_req;
    end
    sn      = s0;
    target  = 1'b0;
    lam_eff = (cfg.mode == MODE_HYB_VAR) ? clamp_lam(s0.lambda_store, LAM_MIN, LAM_MAX)
                                         : lam_req;
    cd1     = (s0.reentry_cooldown != '0) ? s0.reentry_cooldown - 6'd1
                                          : s0.reentry_cooldown;
    trig_hit = frm.core_overflow || enter_hit || (c_34 && d_34) ||
               (!s0.float_active && (cd1 == '0) && frm.switch_hint && sc_gt1 && c_half);

    case (cfg.mode)
      MODE_FLOAT: begin
        target         = 1'b1;
        sn.hold_count  = '0;
        sn.trigger_run = '0;
        sn.calm_run    = '0;
      end
      MODE_HYB_VAR, MODE_HYB_FIX: begin
        sn.reentry_cooldown = cd1;
        if (trig_hit) begin
          if (s0.trigger_run < TRIG_MAX) sn.trigger_run = s0.trigger_run + 2'd1;
          sn.calm_run = '0;
        end else if (calm_c) begin
          sn.trigger_run = '0;
          if (s0.calm_run < CALM_MAX) sn.calm_run = s0.calm_run + 3'd1;
        end else begin
          sn.trigger_run = '0;
          sn.calm_run    = '0;
        end
        if (!s0.float_active) begin
          if (frm.core_overflow || sn.trigger_run >= TRIG_MAX) begin
            target        = 1'b1;
            sn.hold_count = cfg.hold_window;
          end
        end else begin
          target = 1'b1;
          if (frm.core_overflow || trig_hit) begin
            sn.hold_count = cfg.hold_window;
          end else if (s0.hold_count != '0) begin
            sn.hold_count = s0.hold_count - 16'd1;
          end else if (sn.calm_run >= CALM_MAX) begin
            target              = 1'b0;
            sn.reentry_cooldown = COOLDOWN_LOAD;
          end
        end
      end
      default: begin
        sn.hold_count       = '0;
        sn.trigger_run      = '0;
        sn.calm_run         = '0;
        sn.reentry_cooldown = '0;
      end
    endcase

    burst    = 1'b0;
    lam_next = lam_req;
    if (cfg.mode == MODE_HYB_VAR) begin
      burst = (frm.delta_norm > 16'd4096) ||
              ((frm.input_scale > 16'd2048) && dn_020 &&
               (target || (sn.hold_count != '0) || frm.switch_hint)) ||
              ((26'(cond_x2) > thr_x3) && dn_020);
      if (burst) sn.fast_hold = FAST_LOAD;
      else if (s0.fast_hold != '0) sn.fast_hold = s0.fast_hold - 6'd1;

      if (s0.float_active && (26'(frm.cond_est) > thr_x4) && dn_005 &&
          (frm.input_scale > 16'd2048)) begin
        if (s0.steady_run < RUN_MAX) sn.steady_run = s0.steady_run + 4'd1;
      end else begin
        sn.steady_run = '0;
      end
      if (s0.float_active && (29'(frm.cond_est) > thr_x24) && dn_005 &&
          (frm.input_scale > 16'd5120)) begin
        if (s0.extreme_run < RUN_MAX) sn.extreme_run = s0.extreme_run + 4'd1;
      end else begin
        sn.extreme_run = '0;
      end

      if (frm.core_overflow) lam_next = lf;
      else if (sn.extreme_run >= RUN_HIT) lam_next = lb;
      else if (sn.steady_run >= RUN_HIT) lam_next = lm;
      else if (sn.fast_hold != '0) lam_next = lf;
      else if (target || trig_hit || frm.switch_hint || (cond_x5 > 27'(thr_x4)) ||
               (sc_x10 > 20'd3584)) lam_next = lm;
      else if (calm_c) lam_next = lb;
      else lam_next = lam_eff;
    end

    req  = !frm.restart && (target != s0.float_active);
    dir  = req && !s0.float_active;
    done = req && frm.migration_ok;
    if (done) begin
      sn.float_active = target;
      if (!dir) lam_next = bridge_c;
    end
    sn.lambda_store = (cfg.mode == MODE_HYB_VAR || cfg.mode == MODE_HYB_FIX) ?
                      clamp_lam(lam_next, LAM_MIN, LAM_MAX) : lam_req;

    st_nxt                = sn;
    res.use_float         = s0.float_active;
    res.lambda_used       = lam_eff;
    res.want_float        = target;
    res.migrate_request   = req;
    res.migrate_direction = dir;
    res.migrate_done      = done;
    res.active_float      = sn.float_active;
    res.next_lambda       = sn.lambda_store;
  end

endmodule
`default_nettype wire

[hdl/precision_switch_and_lambda_policy_unit.sv]
// Top level: precision switch and forgetting-factor policy, one decision per frame.
// Each frame's result is registered as the frame transfers.
// Throughput: one frame per cycle unless in_stall; result register frees on transfer.
// Reset (rst_n low, synchronous): policy state, configuration and output valid return
// to power-on values (result register not reset); config writes are taken out of reset.
`default_nettype none
module precision_switch_and_lambda_policy_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [pslp_pkg::COND_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_restart,
  input  wire logic [pslp_pkg::COND_W-1:0] in_cond_est,
  input  wire logic [pslp_pkg::DELTA_W-1:0] in_delta_norm,
  input  wire logic [pslp_pkg::SCALE_W-1:0] in_input_scale,
  input  wire logic                        in_switch_hint,
  input  wire logic                        in_core_overflow,
  input  wire logic                        in_migration_ok,
  input  wire logic [pslp_pkg::LAM_W-1:0]  in_bridge_lambda,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_use_float,
  output logic [pslp_pkg::LAM_W-1:0]       out_lambda_used,
  output logic                             out_want_float,
  output logic                             out_migrate_request,
  output logic                             out_migrate_direction,
  output logic                             out_migrate_done,
  output logic                             out_active_float,
  output logic [pslp_pkg::LAM_W-1:0]       out_next_lambda
);
  import pslp_pkg::*;

  pslp_cfg_t    cfg_r;
  pslp_state_t  state_r, state_nxt;
  pslp_result_t res_r, res_nxt;
  pslp_frame_t  frame;
  logic         out_valid_r;
  logic         in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;

  assign frame.restart       = in_restart;
  assign frame.cond_est      = in_cond_est;
  assign frame.delta_norm    = in_delta_norm;
  assign frame.input_scale   = in_input_scale;
  assign frame.switch_hint   = in_switch_hint;
  assign frame.core_overflow = in_core_overflow;
  assign frame.migration_ok  = in_migration_ok;
  assign frame.bridge_lambda = in_bridge_lambda;

  pslp_core u_core (
    .st     (state_r),
    .cfg    (cfg_r),
    .frm    (frame),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{mode: MODE_FIXED, base_lambda: LAM_RESET,
                       cond_limit: COND_DEFAULT, hold_window: '0};
      state_r     <= '{lambda_store: LAM_RESET, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (pslp_cfg_idx_t'(cfg_index))
          CFG_MODE:        cfg_r.mode        <= pslp_mode_t'(cfg_data[1:0]);
          CFG_BASE_LAMBDA: cfg_r.base_lambda <= cfg_data[LAM_W-1:0];
          CFG_COND_LIMIT:  cfg_r.cond_limit  <= cfg_data;
          CFG_HOLD_WINDOW: cfg_r.hold_window <= cfg_data[HOLD_W-1:0];
          default:         cfg_r.mode        <= cfg_r.mode;
        endcase
      end
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_use_float         = res_r.use_float;
  assign out_lambda_used       = res_r.lambda_used;
  assign out_want_float        = res_r.want_float;
  assign out_migrate_request   = res_r.migrate_request;
  assign out_migrate_direction = res_r.migrate_direction;
  assign out_migrate_done      = res_r.migrate_done;
  assign out_active_float      = res_r.active_float;
  assign out_next_lambda       = res_r.next_lambda;

endmodule
`default_nettype wire

[hdl/pslp_checker.sv]
// Port-level checks for the precision switch and lambda policy unit, with bind.
`default_nettype none
`include "precision_switch_and_lambda_policy_unit_macros.svh"
module pslp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       out_use_float,
  input wire logic [pslp_pkg::LAM_W-1:0] out_lambda_used,
  input wire logic                       out_migrate_request,
  input wire logic                       out_migrate_direction,
  input wire logic                       out_migrate_done,
  input wire logic                       out_active_float
);
  import pslp_pkg::*;

  `PSLP_ASSERT_NOW(a_done_needs_req, out_valid && out_migrate_done, out_migrate_request && (out_active_float != out_use_float), "migration done without request or precision change")
  `PSLP_ASSERT_NOW(a_idle_keeps_prec, out_valid && !out_migrate_request, !out_migrate_direction && !out_migrate_done && (out_active_float == out_use_float), "precision changed without a request")
  `PSLP_ASSERT_NOW(a_lambda_range, out_valid, (out_lambda_used >= LAM_MIN) && (out_lambda_used <= LAM_MAX), "lambda used out of range")
  `PSLP_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_lambda_used) && $stable(out_active_float), "stalled result changed")

endmodule

bind precision_switch_and_lambda_policy_unit pslp_checker u_pslp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_use_float         (out_use_float),
  .out_lambda_used       (out_lambda_used),
  .out_migrate_request   (out_migrate_request),
  .out_migrate_direction (out_migrate_direction),
  .out_migrate_done      (out_migrate_done),
  .out_active_float      (out_active_float)
);
`default_nettype wire
